// ----- hdl/wwc_pkg.sv -----
package wwc_pkg;

  // fixed field widths
  localparam int THR_W      = 16;
  localparam int DIM_CFG_W  = 7;
  localparam int OUT_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // parameter defaults
  localparam int MAX_DIM_DEF    = 64;
  localparam int VALUE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH    = 2;

  // integer part of the empty-frame marker, negated on output
  localparam int SENTINEL_INT = 5;

  // register reset values
  localparam logic [THR_W-1:0]     LOW_THR_RST    = 16'd0;
  localparam logic [THR_W-1:0]     HIGH_THR_RST   = 16'd65535;
  localparam logic [DIM_CFG_W-1:0] FRAME_ROWS_RST = 7'd13;
  localparam logic [DIM_CFG_W-1:0] FRAME_COLS_RST = 7'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd3;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ----- hdl/wwc_front.sv -----
module wwc_front import wwc_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_DIM),
  localparam int WS_W  = VALUE_BITS + 2 * CNT_W,
  localparam int SS_W  = WS_W + CNT_W,
  localparam int PK_W  = WS_W + 2 * SS_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  full,
  output logic                  push,
  output logic [PK_W-1:0]       push_data
);

  localparam int E_W   = (DIM_CFG_W > CNT_W + 1) ? DIM_CFG_W : CNT_W + 1;
  localparam int CMP_W = (THR_W > VALUE_BITS) ? THR_W : VALUE_BITS;

  logic [THR_W-1:0]     low_thr;
  logic [THR_W-1:0]     high_thr;
  logic [DIM_CFG_W-1:0] frame_rows;
  logic [DIM_CFG_W-1:0] frame_cols;

  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] col;
  logic [WS_W-1:0]  weight_sum;
  logic [SS_W-1:0]  row_sum;
  logic [SS_W-1:0]  col_sum;

  logic [WS_W-1:0]       weight_sum_next;
  logic [SS_W-1:0]       row_sum_next;
  logic [SS_W-1:0]       col_sum_next;
  logic [E_W-1:0]        rows_eff;
  logic [E_W-1:0]        cols_eff;
  logic                  in_win;
  logic [VALUE_BITS-1:0] wv;
  logic [CNT_W+VALUE_BITS-1:0] row_prod;
  logic [CNT_W+VALUE_BITS-1:0] col_prod;
  logic                  last_col;
  logic                  last_row;
  logic                  accept;

  // out-of-range sizes clamp to 1..MAX_DIM
  always_comb begin
    rows_eff = E_W'(frame_rows);
    if (rows_eff == '0) begin
      rows_eff = E_W'(1);
    end else if (rows_eff > E_W'(MAX_DIM)) begin
      rows_eff = E_W'(MAX_DIM);
    end
    cols_eff = E_W'(frame_cols);
    if (cols_eff == '0) begin
      cols_eff = E_W'(1);
    end else if (cols_eff > E_W'(MAX_DIM)) begin
      cols_eff = E_W'(MAX_DIM);
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  assign in_win = (CMP_W'(low_thr) <= CMP_W'(in_value)) &&
                  (CMP_W'(in_value) <= CMP_W'(high_thr));
  assign wv       = in_win ? in_value : '0;
  assign row_prod = row * wv;
  assign col_prod = col * wv;

  assign weight_sum_next = weight_sum + WS_W'(wv);
  assign row_sum_next    = row_sum + SS_W'(row_prod);
  assign col_sum_next    = col_sum + SS_W'(col_prod);

  assign last_col = (E_W'(col) + E_W'(1)) >= cols_eff;
  assign last_row = (E_W'(row) + E_W'(1)) >= rows_eff;

  assign push      = accept && last_col && last_row;
  assign push_data = {col_sum_next, row_sum_next, weight_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr    <= LOW_THR_RST;
      high_thr   <= HIGH_THR_RST;
      frame_rows <= FRAME_ROWS_RST;
      frame_cols <= FRAME_COLS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_THR:    low_thr    <= cfg_data[THR_W-1:0];
        REG_HIGH_THR:   high_thr   <= cfg_data[THR_W-1:0];
        REG_FRAME_ROWS: frame_rows <= cfg_data[DIM_CFG_W-1:0];
        REG_FRAME_COLS: frame_cols <= cfg_data[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      weight_sum <= '0;
      row_sum    <= '0;
      col_sum    <= '0;
    end else if (accept) begin
      if (push) begin
        row        <= '0;
        col        <= '0;
        weight_sum <= '0;
        row_sum    <= '0;
        col_sum    <= '0;
      end else begin
        weight_sum <= weight_sum_next;
        row_sum    <= row_sum_next;
        col_sum    <= col_sum_next;
        if (last_col) begin
          col <= '0;
          row <= row + CNT_W'(1);
        end else begin
          col <= col + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ----- hdl/wwc_fifo.sv -----
module wwc_fifo import wwc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- hdl/wwc_back.sv -----
module wwc_back import wwc_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_DIM),
  localparam int WS_W  = VALUE_BITS + 2 * CNT_W,
  localparam int SS_W  = WS_W + CNT_W,
  localparam int PK_W  = WS_W + 2 * SS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  logic [PK_W-1:0]  pop_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_row,
  output logic [OUT_W-1:0] out_col,
  output logic             out_empty
);

  // quotient bits: integer part below MAX_DIM plus fraction
  localparam int Q_W  = CNT_W + FRAC_BITS;
  localparam int QX_W = (Q_W > OUT_W) ? Q_W : OUT_W;
  localparam int N_W  = SS_W + FRAC_BITS;
  localparam int SC_W = $clog2(Q_W + 1);
  localparam logic [OUT_W-1:0] SENTINEL = OUT_W'(-(SENTINEL_INT * (2 ** FRAC_BITS)));

  back_state_t state;
  back_state_t state_next;

  logic [WS_W-1:0] den;
  logic [WS_W-1:0] row_rem;
  logic [WS_W-1:0] col_rem;
  logic [Q_W-1:0]  row_lo;
  logic [Q_W-1:0]  col_lo;
  logic [QX_W-1:0] row_q;
  logic [QX_W-1:0] col_q;
  logic [SC_W-1:0] steps;

  logic [WS_W-1:0] in_w;
  logic [N_W-1:0]  row_num;
  logic [N_W-1:0]  col_num;
  logic [WS_W:0]   row_trial;
  logic [WS_W:0]   col_trial;
  logic            row_ge;
  logic            col_ge;
  logic            out_free;
  logic            load_div;
  logic            load_empty;
  logic            load_done;
  logic            do_step;

  assign in_w    = pop_data[WS_W-1:0];
  assign row_num = N_W'(pop_data[WS_W+SS_W-1:WS_W]) << FRAC_BITS;
  assign col_num = N_W'(pop_data[PK_W-1:WS_W+SS_W]) << FRAC_BITS;

  assign out_free = !out_valid || out_ready;

  // restoring step, one quotient bit per cycle for both coordinates
  assign row_trial = {row_rem, row_lo[Q_W-1]};
  assign col_trial = {col_rem, col_lo[Q_W-1]};
  assign row_ge    = row_trial >= {1'b0, den};
  assign col_ge    = col_trial >= {1'b0, den};

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_div   = 1'b0;
    load_empty = 1'b0;
    load_done  = 1'b0;
    do_step    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          if (in_w != '0) begin
            pop        = 1'b1;
            load_div   = 1'b1;
            state_next = B_DIV;
          end else if (out_free) begin
            pop        = 1'b1;
            load_empty = 1'b1;
          end
        end
      end
      B_DIV: begin
        do_step = 1'b1;
        if (steps == SC_W'(1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          load_done  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_div) begin
      den     <= in_w;
      row_rem <= row_num[N_W-1:Q_W];
      col_rem <= col_num[N_W-1:Q_W];
      row_lo  <= row_num[Q_W-1:0];
      col_lo  <= col_num[Q_W-1:0];
      row_q   <= '0;
      col_q   <= '0;
      steps   <= SC_W'(Q_W);
    end else if (do_step) begin
      row_rem <= row_ge ? WS_W'(row_trial - {1'b0, den}) : row_trial[WS_W-1:0];
      col_rem <= col_ge ? WS_W'(col_trial - {1'b0, den}) : col_trial[WS_W-1:0];
      row_lo  <= row_lo << 1;
      col_lo  <= col_lo << 1;
      row_q   <= {row_q[QX_W-2:0], row_ge};
      col_q   <= {col_q[QX_W-2:0], col_ge};
      steps   <= steps - SC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      out_row   <= SENTINEL;
      out_col   <= SENTINEL;
      out_empty <= 1'b1;
    end else if (load_done) begin
      out_row   <= row_q[OUT_W-1:0];
      out_col   <= col_q[OUT_W-1:0];
      out_empty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_empty || load_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hdl/windowed_weighted_centroid_top.sv -----
// channel | direction | beat contents
// --------+-----------+----------------------------------------------------------
// s_*     | in        | one texel value, row-major order
// m_*     | out       | one centroid per frame: row and column in q.8, empty flag
// cfg_*   | in        | register index and write data
//
// the front end takes one texel every cycle while the queue is not full and keeps the running sums
// each finished frame drops its sums into a two-entry queue
// the back end divides each frame, one at a time, with
// one restoring step unit that yields a quotient bit per cycle for both coordinates
// s_tready falls only while the queue is full; a pending result blocks the front only once the queue fills
// synchronous reset clears counters, sums, queue and output valid; no memory clearing pass
module windowed_weighted_centroid_top import wwc_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int S_W = ((VALUE_BITS + 7) / 8) * 8,
  localparam int M_W = ((2 * OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // texel stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_W-1:0]        s_tdata,    // texel_value
  // centroid stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_W-1:0]        m_tdata,    // centroid_row, centroid_col
  output logic                  m_tuser,    // frame_empty
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int WS_W  = VALUE_BITS + 2 * CNT_W;
  localparam int SS_W  = WS_W + CNT_W;
  localparam int PK_W  = WS_W + 2 * SS_W;

  logic             push;
  logic [PK_W-1:0]  push_data;
  logic             full;
  logic             pop;
  logic             empty;
  logic [PK_W-1:0]  pop_data;
  logic [OUT_W-1:0] out_row;
  logic [OUT_W-1:0] out_col;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  wwc_front #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata[VALUE_BITS-1:0]),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // frame sums waiting for the divider
  wwc_fifo #(
    .WIDTH (PK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  wwc_back #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_empty (m_tuser)
  );

  // row in the low bits, column above, zero pad to whole bytes
  assign m_tdata = M_W'({out_col, out_row});

endmodule

// ----- verif/tb_windowed_weighted_centroid_top.sv -----
module tb_windowed_weighted_centroid_top import wwc_pkg::*;;

  localparam int S_W          = 16;
  localparam int M_W          = 32;
  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int MAX_DIM      = MAX_DIM_DEF;
  localparam int RANDOM_ITEMS = 1700;
  // back end divides one frame at a time, two frames can be queued
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam logic signed [OUT_W-1:0] EMPTY_MARK = OUT_W'(-(SENTINEL_INT << FRAC));

  // one centroid beat split into its fields
  typedef struct packed {
    logic signed [OUT_W-1:0] row;
    logic signed [OUT_W-1:0] col;
    logic                    empty;
  } centroid_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_W-1:0]        s_tdata = '0;    // texel_value
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_W-1:0]        m_tdata;         // centroid_row, centroid_col
  logic                  m_tuser;         // frame_empty
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  windowed_weighted_centroid_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // texels waiting for the driver, centroids waiting for the block
  logic [S_W-1:0] texel_q[$];
  centroid_t      centroid_q[$];

  // mirror of the register file, starts at the reset values
  logic [THR_W-1:0]     thr_lo   = LOW_THR_RST;
  logic [THR_W-1:0]     thr_hi   = HIGH_THR_RST;
  logic [DIM_CFG_W-1:0] rows_cfg = FRAME_ROWS_RST;
  logic [DIM_CFG_W-1:0] cols_cfg = FRAME_COLS_RST;

  // running sums and scan position of the frame in progress
  bit [63:0]   wsum = '0;
  bit [63:0]   rsum = '0;
  bit [63:0]   csum = '0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  // idle knobs set per phase by the stimulus process
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int errors = 0;
  int texels_sent = 0;
  int centroids_checked = 0;
  int reg_writes = 0;
  int phases = 0;
  int quiet = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // 0 acts as 1, anything above the array size acts as the array size
  function automatic int unsigned clamp_dim(input int unsigned d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // fold one accepted texel into the sums, queue a centroid on the last one
  task automatic accumulate_texel(input logic [S_W-1:0] v);
    int unsigned nrows;
    int unsigned ncols;
    centroid_t   c;
    nrows = clamp_dim(rows_cfg);
    ncols = clamp_dim(cols_cfg);
    // inclusive window, an inverted window lets nothing through
    if (v >= thr_lo && v <= thr_hi) begin
      wsum += 64'(v);
      rsum += 64'(row_pos) * 64'(v);
      csum += 64'(col_pos) * 64'(v);
    end
    // counters compare against the current size, so a shrink mid-frame ends early
    if (col_pos + 1 < ncols) begin
      col_pos++;
    end else if (row_pos + 1 < nrows) begin
      col_pos = 0;
      row_pos++;
    end else begin
      if (wsum == 0) begin
        // no weight gathered, e.g. all texels outside the window or all zero
        c.row   = EMPTY_MARK;
        c.col   = EMPTY_MARK;
        c.empty = 1'b1;
      end else begin
        c.row   = OUT_W'((rsum << FRAC) / wsum);
        c.col   = OUT_W'((csum << FRAC) / wsum);
        c.empty = 1'b0;
      end
      centroid_q = {centroid_q, c};
      wsum = '0;
      rsum = '0;
      csum = '0;
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // texel driver: holds a beat until taken, then offers the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        accumulate_texel(s_tdata);
        texels_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (texel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= texel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // centroid monitor and ready generator
  always @(posedge clk) begin
    centroid_t exp_c;
    centroid_t got_c;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_c.row   = m_tdata[OUT_W-1:0];
        got_c.col   = m_tdata[2*OUT_W-1:OUT_W];
        got_c.empty = m_tuser;
        if (centroid_q.size() == 0) begin
          errors++;
          $display("%0t: centroid beat with none expected, row %0d col %0d empty %0d",
                   $time, got_c.row, got_c.col, got_c.empty);
        end else begin
          exp_c = centroid_q.pop_front();
          centroids_checked++;
          if (got_c.row !== exp_c.row) begin
            errors++;
            $display("%0t: centroid_row mismatch, expected %0d, got %0d",
                     $time, exp_c.row, got_c.row);
          end
          if (got_c.col !== exp_c.col) begin
            errors++;
            $display("%0t: centroid_col mismatch, expected %0d, got %0d",
                     $time, exp_c.col, got_c.col);
          end
          if (got_c.empty !== exp_c.empty) begin
            errors++;
            $display("%0t: frame_empty mismatch, expected %0d, got %0d",
                     $time, exp_c.empty, got_c.empty);
          end
        end
      end
      // long hold-off on request, counted here so the sender runs freely meanwhile
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog on cycles without any beat on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("windowed_weighted_centroid_top test failed");
        $finish;
      end
    end
  end

  // one register write, mirrored once the beat is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LOW_THR:    thr_lo   = THR_W'(val);
      REG_HIGH_THR:   thr_hi   = THR_W'(val);
      REG_FRAME_ROWS: rows_cfg = DIM_CFG_W'(val);
      REG_FRAME_COLS: cols_cfg = DIM_CFG_W'(val);
      default: ;
    endcase
    reg_writes++;
  endtask

  // wait until every texel is taken and every centroid has come back,
  // then let a partial frame or a division in flight settle
  task automatic drain();
    while (texel_q.size() != 0 || s_tvalid || centroid_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input int unsigned lo, input int unsigned hi,
                           input int unsigned r, input int unsigned c);
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_FRAME_ROWS, r);
    write_reg(REG_FRAME_COLS, c);
  endtask

  initial begin
    int unsigned r;
    int unsigned c;
    int unsigned lo;
    int unsigned hi;
    int unsigned nfr;
    int unsigned total;
    int unsigned random_items;
    logic [S_W-1:0] v;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset sizes 13 x 6: a single heavy texel in the bottom-right corner
    for (int i = 0; i < 78; i++) texel_q = {texel_q, (i == 77) ? 16'hFFFF : 16'h0000};
    drain();

    // 1 x 1 frames: a zero texel gives the empty marker, then value extremes
    write_all(0, 65535, 1, 1);
    texel_q = {16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
    drain();

    // 2 x 2 with a narrow window: edges of the window count, one past them not
    write_all(100, 200, 2, 2);
    texel_q = {16'd99, 16'd100, 16'd200, 16'd201, 16'd50, 16'd60, 16'd70, 16'd80};
    drain();

    // inverted window, nothing counts
    write_all(500, 400, 1, 2);
    texel_q = {16'd450, 16'd500};
    drain();

    // zero sizes act as 1 x 1
    write_all(0, 65535, 0, 0);
    texel_q = {16'd7, 16'd0};
    drain();

    // random phases; a leftover partial frame makes the next setting
    // take effect mid-frame
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain();
      case (phases % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
        default: begin src_idle_pct = 38; sink_stall_pct = 38; end
      endcase

      // frame size: mostly tiny, sometimes medium, now and then one side at the limit
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin r = $urandom_range(1, 4);  c = $urandom_range(1, 4); end
        6, 7: begin r = $urandom_range(1, 12); c = $urandom_range(1, 8); end
        8: begin r = $urandom_range(64, 127); c = $urandom_range(0, 2); end
        default: begin r = $urandom_range(0, 2); c = $urandom_range(64, 127); end
      endcase

      // window: full, random, inverted, single value, open at one end
      case ($urandom_range(5))
        0: begin lo = 0; hi = 65535; end
        1: begin lo = $urandom_range(65535); hi = $urandom_range(65535, lo); end
        2: begin lo = $urandom_range(1, 65535); hi = $urandom_range(lo - 1, 0); end
        3: begin lo = $urandom_range(65535); hi = lo; end
        4: begin lo = 0; hi = $urandom_range(65535); end
        default: begin lo = $urandom_range(65535); hi = 65535; end
      endcase

      // one phase of short frames with the output held off so the queue fills
      if (phases == 5) begin
        r = 1;
        c = 2;
        lo = 0;
        hi = 65535;
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      write_all(lo, hi, r, c);

      total = clamp_dim(r) * clamp_dim(c);
      nfr = (total >= 60) ? 1 : 60 / total;
      total = total * nfr;
      if (phases == 5) begin
        total = 80;
        hold_reqs++;
      end else if ($urandom_range(3) == 0 && clamp_dim(r) * clamp_dim(c) > 1) begin
        total += $urandom_range(1, clamp_dim(r) * clamp_dim(c) - 1);
      end

      for (int i = 0; i < total; i++) begin
        case ($urandom_range(9))
          0, 1: v = '0;
          2: v = '1;
          3: v = S_W'(lo);
          4: v = S_W'(hi);
          5, 6, 7: v = (lo <= hi) ? S_W'($urandom_range(hi, lo)) : S_W'($urandom);
          default: v = S_W'($urandom);
        endcase
        texel_q = {texel_q, v};
      end
      random_items += total;
      phases++;
    end
    drain();

    $display("covered %0d texels and %0d centroids over %0d random phases, %0d register writes",
             texels_sent, centroids_checked, phases, reg_writes);
    $display("sizes 1x1 to 64 on a side, window edges, inverted and empty frames, output hold-off");
    if (errors == 0) begin
      $display("windowed_weighted_centroid_top test passed");
    end else begin
      $display("windowed_weighted_centroid_top test failed");
    end
    $finish;
  end

endmodule
